### sv/cc2ak_pkg.sv
// Package for char_code_to_alt_keystrokes: report constants, digit-unit
// control and status structs, power-of-ten table. No dependencies.
`default_nettype none

package cc2ak_pkg;

  localparam int unsigned CodeW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDig  = 5;
  localparam int unsigned PowIdxW = 3;

  localparam logic [ByteW-1:0] ModNone  = 8'h00;
  localparam logic [ByteW-1:0] ModShift = 8'h20;
  localparam logic [ByteW-1:0] ModAlt   = 8'h40;
  localparam logic [ByteW-1:0] KeyNone  = 8'd0;
  localparam logic [ByteW-1:0] KeyPad0  = 8'd98;
  localparam logic [ByteW-1:0] KeyBase  = 8'd88;
  localparam logic [ByteW-1:0] ScMask   = 8'b0111_1111;

  typedef struct packed {
    logic load;      // take a new code, start at the top power
    logic step;      // subtract current power if it fits
    logic next_pow;  // move to the next lower power, clear digit
  } dec_ctrl_t;

  typedef struct packed {
    logic                ge;        // remainder >= current power
    logic                last_pow;  // working on the units digit
    logic [DigitW-1:0]   digit;
  } dec_stat_t;

  function automatic logic [CodeW-1:0] pow10(input logic [PowIdxW-1:0] idx);
    logic [CodeW-1:0] p;
    case (idx)
      3'd0:    p = 16'd10000;
      3'd1:    p = 16'd1000;
      3'd2:    p = 16'd100;
      3'd3:    p = 16'd10;
      3'd4:    p = 16'd1;
      default: p = 16'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### sv/cc2ak_dec_unit.sv
// Decimal digit unit: one compare/subtract per stepped cycle against a power of ten.
// Depends on cc2ak_pkg.
`default_nettype none

module cc2ak_dec_unit (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire cc2ak_pkg::dec_ctrl_t  ctrl_i,
  input  wire [cc2ak_pkg::CodeW-1:0] code_i,
  output cc2ak_pkg::dec_stat_t       stat_o
);
  import cc2ak_pkg::*;

  logic [CodeW-1:0]   rem_q, rem_d;
  logic [PowIdxW-1:0] pow_idx_q, pow_idx_d;
  logic [DigitW-1:0]  digit_q, digit_d;
  logic [CodeW-1:0]   pow;
  logic               ge;

  assign pow = pow10(pow_idx_q);
  assign ge  = (rem_q >= pow);

  always_comb begin
    rem_d     = rem_q;
    pow_idx_d = pow_idx_q;
    digit_d   = digit_q;
    if (ctrl_i.load) begin
      rem_d     = code_i;
      pow_idx_d = '0;
      digit_d   = '0;
    end else if (ctrl_i.step) begin
      if (ge) begin
        rem_d   = rem_q - pow;
        digit_d = digit_q + 4'd1;
      end
    end else if (ctrl_i.next_pow) begin
      pow_idx_d = pow_idx_q + 3'd1;
      digit_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow_idx_q <= '0;
      digit_q   <= '0;
    end else begin
      pow_idx_q <= pow_idx_d;
      digit_q   <= digit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign stat_o.ge       = ge;
  assign stat_o.last_pow = (pow_idx_q == PowIdxW'(NumDig - 1));
  assign stat_o.digit    = digit_q;

endmodule

`default_nettype wire

### sv/char_code_to_alt_keystrokes.sv
// Top level: character code in, keyboard reports out, via a small sequencer.
// Depends on cc2ak_pkg and cc2ak_dec_unit.
//
// One 16-bit code per request; the block is busy until its last report has
// been loaded into the output register. High byte zero: a nonzero low byte
// gives a press and a release report, a zero code gives nothing and the
// block is ready again the next cycle. Otherwise an Alt-numpad run of 12
// reports: Alt down, press/release per decimal digit (most significant
// first), Alt up. Digits come from one shared compare/subtract unit stepping
// down 10000..1, one subtraction per cycle plus one failing compare per
// digit; the run also waits on any output stall.
`default_nettype none

module char_code_to_alt_keystrokes (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,   // [15:0] char_code
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] modifier, [15:8] keycode
  output logic        m_axis_tlast_o    // last
);
  import cc2ak_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SC_PRESS = 3'd1;
  localparam logic [2:0] S_SC_REL   = 3'd2;
  localparam logic [2:0] S_ALT_DN   = 3'd3;
  localparam logic [2:0] S_DIG      = 3'd4;
  localparam logic [2:0] S_PRESS    = 3'd5;
  localparam logic [2:0] S_REL      = 3'd6;
  localparam logic [2:0] S_ALT_UP   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [ByteW-1:0] lo_q, lo_d;
  logic             ovalid_q, ovalid_d;
  logic [ByteW-1:0] mod_q, mod_d, key_q, key_d;
  logic             last_q, last_d;

  dec_ctrl_t dctrl;
  dec_stat_t dstat;

  logic             accept;
  logic             emit_ok;
  logic             emit;
  logic [ByteW-1:0] emit_mod, emit_key;
  logic             emit_last;
  logic [ByteW-1:0] pad_key;

  cc2ak_dec_unit u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dctrl),
    .code_i (s_axis_tdata_i),
    .stat_o (dstat)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign emit_ok         = !ovalid_q || m_axis_tready_i;
  assign pad_key = (dstat.digit == '0) ? KeyPad0 : (KeyBase + ByteW'(dstat.digit));

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    dctrl     = '0;
    emit      = 1'b0;
    emit_mod  = ModNone;
    emit_key  = KeyNone;
    emit_last = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          lo_d = s_axis_tdata_i[ByteW-1:0];
          if (s_axis_tdata_i[CodeW-1:ByteW] != '0) begin
            dctrl.load = 1'b1;
            state_d    = S_ALT_DN;
          end else if (s_axis_tdata_i[ByteW-1:0] != '0) begin
            state_d = S_SC_PRESS;
          end
        end
      end
      S_SC_PRESS: begin
        emit     = emit_ok;
        emit_mod = lo_q[ByteW-1] ? ModShift : ModNone;
        emit_key = lo_q & ScMask;
        if (emit_ok) state_d = S_SC_REL;
      end
      S_SC_REL: begin
        emit      = emit_ok;
        emit_last = 1'b1;
        if (emit_ok) state_d = S_IDLE;
      end
      S_ALT_DN: begin
        emit     = emit_ok;
        emit_mod = ModAlt;
        if (emit_ok) state_d = S_DIG;
      end
      S_DIG: begin
        if (dstat.ge) dctrl.step = 1'b1;
        else          state_d    = S_PRESS;
      end
      S_PRESS: begin
        emit     = emit_ok;
        emit_mod = ModAlt;
        emit_key = pad_key;
        if (emit_ok) state_d = S_REL;
      end
      S_REL: begin
        emit     = emit_ok;
        emit_mod = ModAlt;
        if (emit_ok) begin
          if (dstat.last_pow) begin
            state_d = S_ALT_UP;
          end else begin
            dctrl.next_pow = 1'b1;
            state_d        = S_DIG;
          end
        end
      end
      S_ALT_UP: begin
        emit      = emit_ok;
        emit_last = 1'b1;
        if (emit_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    mod_d    = mod_q;
    key_d    = key_q;
    last_d   = last_q;
    if (emit) begin
      ovalid_d = 1'b1;
      mod_d    = emit_mod;
      key_d    = emit_key;
      last_d   = emit_last;
    end else if (m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    mod_q  <= mod_d;
    key_q  <= key_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {key_q, mod_q};
  assign m_axis_tlast_o  = last_q;

endmodule

`default_nettype wire

### sv/cc2ak_checker.sv
// Port-level checker for char_code_to_alt_keystrokes and its bind.
// Depends on the top level's port list only.
`default_nettype none

module cc2ak_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid_i,
  input wire        s_axis_tready_o,
  input wire [15:0] s_axis_tdata_i,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [15:0] m_axis_tdata_o,
  input wire        m_axis_tlast_o
);

  // a nonzero request starts a run, so the input side closes
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i != 16'h0000)
    |=> !s_axis_tready_o)
    else $error("ready stayed high after a nonzero request");

  // while a non-final report is pending the run is not finished
  a_no_ready_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready while a run is still in flight");

  // every run ends with an all-released report
  a_last_is_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o == 16'h0000)
    else $error("final report is not a full release");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i
    |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled report changed");

endmodule

bind char_code_to_alt_keystrokes cc2ak_checker u_cc2ak_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

### sim/char_code_to_alt_keystrokes_test.sv
// Testbench for char_code_to_alt_keystrokes: drives character codes on the
// input stream, checks every report against table rows or an internal predictor.
// Depends on cc2ak_pkg and the char_code_to_alt_keystrokes RTL.
`timescale 1ns / 1ps

module char_code_to_alt_keystrokes_test;
  import cc2ak_pkg::*;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] keycode;
    logic       last;
  } report_t;

  // typed = 1: expected reports are given in the row (n of them)
  typedef struct packed {
    logic [15:0] code;
    logic        typed;
    logic [1:0]  n;
    report_t     press;
    report_t     release_rpt;
  } code_vec_t;

  localparam int NumVecs = 23;
  localparam report_t NoRpt = '0;
  localparam report_t KeyUp = '{8'h00, 8'h00, 1'b1};

  localparam code_vec_t CodeVecs [NumVecs] = '{
    '{16'h0000, 1'b1, 2'd0, NoRpt, NoRpt},
    '{16'h0001, 1'b1, 2'd2, '{8'h00, 8'h01, 1'b0}, KeyUp},
    '{16'h007F, 1'b1, 2'd2, '{8'h00, 8'h7F, 1'b0}, KeyUp},
    '{16'h0080, 1'b1, 2'd2, '{8'h20, 8'h00, 1'b0}, KeyUp},
    '{16'h00FF, 1'b1, 2'd2, '{8'h20, 8'h7F, 1'b0}, KeyUp},
    '{16'h0055, 1'b1, 2'd2, '{8'h00, 8'h55, 1'b0}, KeyUp},
    '{16'h00AA, 1'b1, 2'd2, '{8'h20, 8'h2A, 1'b0}, KeyUp},
    '{16'h0000, 1'b1, 2'd0, NoRpt, NoRpt},
    '{16'h0100, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'h01FF, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'h0101, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'hFFFF, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'h8000, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'h7FFF, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'h2710, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'h270F, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'h2711, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'hD431, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'hC350, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'hAAAA, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'h5555, 1'b0, 2'd0, NoRpt, NoRpt},
    '{16'h0000, 1'b1, 2'd0, NoRpt, NoRpt},
    '{16'h0D80, 1'b0, 2'd0, NoRpt, NoRpt}
  };

  logic        clk_i;
  logic        rst_n     = 1'b0;
  logic        s_valid   = 1'b0;
  logic [15:0] s_data    = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready   = 1'b0;
  logic [15:0] m_data;
  logic        m_last;
  bit          calm      = 1'b0;
  int          errors    = 0;

  report_t expected_reports[$];

  char_code_to_alt_keystrokes u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void predict_keystrokes(input logic [15:0] code);
    int unsigned digits [5];
    int unsigned v;
    if (code[15:8] == 8'h00) begin
      if (code[7:0] == 8'h00) return;
      expected_reports.push_back('{code[7] ? ModShift : ModNone, code[7:0] & ScMask, 1'b0});
      expected_reports.push_back('{ModNone, KeyNone, 1'b1});
      return;
    end
    v = code;
    for (int i = 4; i > 0; i--) begin
      digits[i] = v % 10;
      v = v / 10;
    end
    digits[0] = v;
    expected_reports.push_back('{ModAlt, KeyNone, 1'b0});
    for (int i = 0; i < 5; i++) begin
      expected_reports.push_back('{ModAlt,
          (digits[i] == 0) ? KeyPad0 : KeyBase + 8'(digits[i]), 1'b0});
      expected_reports.push_back('{ModAlt, KeyNone, 1'b0});
    end
    expected_reports.push_back('{ModNone, KeyNone, 1'b1});
  endfunction

  // returns once the request has been taken
  task automatic send_code(input logic [15:0] code);
    while (!calm && $urandom_range(99) < 9) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= code;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) m_ready <= calm || ($urandom_range(99) >= 9);

  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    if (rst_n && m_valid && m_ready) begin
      got = '{m_data[7:0], m_data[15:8], m_last};
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report mod=%h key=%h last=%b",
                 $realtime, got.modifier, got.keycode, got.last);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          $display("%0t: expected mod=%h key=%h last=%b, got mod=%h key=%h last=%b",
                   $realtime, want.modifier, want.keycode, want.last,
                   got.modifier, got.keycode, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [15:0] code;
    int          typed_codes;
    int          pick;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (CodeVecs[i]) begin
      send_code(CodeVecs[i].code);
      if (CodeVecs[i].typed) begin
        if (CodeVecs[i].n == 2'd2) begin
          expected_reports.push_back(CodeVecs[i].press);
          expected_reports.push_back(CodeVecs[i].release_rpt);
        end
      end else begin
        predict_keystrokes(CodeVecs[i].code);
      end
    end

    typed_codes = 0;
    while (typed_codes < 77) begin
      calm = (typed_codes >= 30 && typed_codes < 55);
      pick = $urandom_range(99);
      if (pick < 35)
        code = {8'h00, 8'($urandom_range(255))};
      else if (pick < 45)
        code = {8'($urandom_range(1, 3)), 8'($urandom_range(255))};
      else
        code = 16'($urandom_range(16'h0100, 16'hFFFF));
      send_code(code);
      predict_keystrokes(code);
      if (code != 16'h0000) typed_codes++;
    end
    calm = 1'b0;
    s_valid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
